// ===== rtl/core/ble_pkg.sv =====
// Shared types and codes for the bounded list edit engine.
`default_nettype none

package ble_pkg;

	localparam logic [3:0] ACT_APPEND    = 4'd0;
	localparam logic [3:0] ACT_REMOVE_EQ = 4'd1;
	localparam logic [3:0] ACT_READ      = 4'd2;
	localparam logic [3:0] ACT_SWAP      = 4'd3;
	localparam logic [3:0] ACT_DROP      = 4'd4;
	localparam logic [3:0] ACT_ROT_R     = 4'd5;
	localparam logic [3:0] ACT_ROT_L     = 4'd6;
	localparam logic [3:0] ACT_MOVE2     = 4'd7;
	localparam logic [3:0] ACT_REMOVE_LT = 4'd8;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_NOCHG = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_ELEM = 1'b1;

	typedef enum logic [3:0] {
		OP_APPEND,
		OP_REMOVE_EQ,
		OP_READ,
		OP_SWAP,
		OP_DROP,
		OP_ROT_R,
		OP_ROT_L,
		OP_MOVE2,
		OP_REMOVE_LT,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [3:0]         action;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] element;
		logic               last;
		logic [5:0]         entry_count;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/ble_front.sv =====
// Front end: accepts and classifies actions, holds them in a two-entry command queue.
`default_nettype none

module ble_front import ble_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  item_t item,
	output logic  q_valid,
	output cmd_t  q_cmd,
	input  logic  pop
);

	cmd_t       fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;
	logic       push;
	op_t        op;

	always_comb begin
		unique case (item.action)
			ACT_APPEND:    op = OP_APPEND;
			ACT_REMOVE_EQ: op = OP_REMOVE_EQ;
			ACT_READ:      op = OP_READ;
			ACT_SWAP:      op = OP_SWAP;
			ACT_DROP:      op = OP_DROP;
			ACT_ROT_R:     op = OP_ROT_R;
			ACT_ROT_L:     op = OP_ROT_L;
			ACT_MOVE2:     op = OP_MOVE2;
			ACT_REMOVE_LT: op = OP_REMOVE_LT;
			default:       op = OP_NOP;
		endcase
	end

	assign busy    = (fill_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign q_cmd   = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= '{op: op, value: item.value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop && q_valid) rptr_q <= ~rptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop && q_valid);
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== rtl/core/ble_back.sv =====
// Back end: ring store of entries and the sequencer that carries out each action.
`default_nettype none

module ble_back import ble_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	input  cmd_t    q_cmd,
	output logic    pop,
	output logic    strobe,
	output result_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

	state_t             state_q;
	op_t                op_q;
	logic signed [31:0] val_q;
	logic [AW-1:0]      front_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      jend_q;
	logic               issued_q;
	logic [CW-1:0]      k_q;
	logic               found_q;
	logic signed [31:0] sv_q;
	logic               vld_s1;
	logic [CW-1:0]      j_s1;
	logic signed [31:0] rdata_s1;
	logic               strobe_q;
	result_t            result_q;

	logic [31:0]        entry_mem [DEPTH];

	logic               issue;
	logic               proc;
	logic               last_rd;
	logic               keep;
	logic               is_filter;
	logic [AW-1:0]      raddr;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata;
	logic [AW-1:0]      front_dec;
	logic [AW-1:0]      front_inc;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
			input logic [CW-1:0] idx);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(idx);
		if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic logic [5:0] cnt6(input logic [CW-1:0] c);
		logic [CW+5:0] w;
		w = (CW + 6)'(c);
		return w[5:0];
	endfunction

	function automatic result_t make_ack(input logic [1:0] st, input logic [CW-1:0] c);
		result_t r;
		r.kind        = KIND_ACK;
		r.element     = '0;
		r.last        = 1'b1;
		r.entry_count = cnt6(c);
		r.status      = st;
		return r;
	endfunction

	function automatic result_t make_elem(input logic signed [31:0] e, input logic l,
			input logic [CW-1:0] c);
		result_t r;
		r.kind        = KIND_ELEM;
		r.element     = e;
		r.last        = l;
		r.entry_count = cnt6(c);
		r.status      = ST_DONE;
		return r;
	endfunction

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

	assign pop       = (state_q == S_IDLE) && q_valid;
	assign issue     = (state_q == S_SCAN) && !issued_q;
	assign proc      = (state_q == S_SCAN) && vld_s1;
	assign last_rd   = proc && (j_s1 == jend_q);
	assign raddr     = slot(front_q, j_q);
	assign is_filter = (op_q == OP_REMOVE_EQ) || (op_q == OP_REMOVE_LT)
		|| (op_q == OP_MOVE2);

	always_comb begin
		case (op_q)
			OP_REMOVE_EQ: keep = found_q || (rdata_s1 != val_q);
			OP_REMOVE_LT: keep = (rdata_s1 >= val_q);
			OP_MOVE2:     keep = (j_s1 != CW'(1));
			default:      keep = 1'b0;
		endcase
	end

	// single write port shared by append, compaction, the swap step and the closing write
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				if (pop && q_cmd.op == OP_APPEND && cnt_q < CW'(DEPTH)) begin
					we    = 1'b1;
					waddr = slot(front_q, cnt_q);
					wdata = q_cmd.value;
				end
			end
			S_SCAN: begin
				if (proc && is_filter && keep) begin
					we    = 1'b1;
					waddr = slot(front_q, k_q);
					wdata = rdata_s1;
				end else if (proc && op_q == OP_SWAP && j_s1 == CW'(1)) begin
					we    = 1'b1;
					waddr = front_q;
					wdata = rdata_s1;
				end
			end
			S_FIN: begin
				case (op_q)
					OP_MOVE2: begin
						we    = 1'b1;
						waddr = slot(front_q, cnt_q - CW'(1));
						wdata = sv_q;
					end
					OP_SWAP: begin
						we    = 1'b1;
						waddr = slot(front_q, CW'(1));
						wdata = sv_q;
					end
					OP_ROT_R: begin
						we    = 1'b1;
						waddr = front_dec;
						wdata = sv_q;
					end
					OP_ROT_L: begin
						we    = 1'b1;
						waddr = slot(front_q, cnt_q);
						wdata = sv_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) entry_mem[waddr] <= wdata;
		rdata_s1 <= entry_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_NOP;
			val_q    <= '0;
			front_q  <= '0;
			cnt_q    <= '0;
			j_q      <= '0;
			jend_q   <= '0;
			issued_q <= 1'b0;
			k_q      <= '0;
			found_q  <= 1'b0;
			sv_q     <= '0;
			vld_s1   <= 1'b0;
			j_s1     <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			vld_s1   <= issue;
			j_s1     <= j_q;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						op_q     <= q_cmd.op;
						val_q    <= q_cmd.value;
						k_q      <= '0;
						found_q  <= 1'b0;
						issued_q <= 1'b0;
						j_q      <= '0;
						case (q_cmd.op) inside
							OP_APPEND: begin
								strobe_q <= 1'b1;
								if (cnt_q < CW'(DEPTH)) begin
									cnt_q    <= cnt_q + CW'(1);
									result_q <= make_ack(ST_DONE, cnt_q + CW'(1));
								end else begin
									result_q <= make_ack(ST_FULL, cnt_q);
								end
							end
							OP_DROP: begin
								strobe_q <= 1'b1;
								if (cnt_q != '0) begin
									cnt_q    <= cnt_q - CW'(1);
									result_q <= make_ack(ST_DONE, cnt_q - CW'(1));
								end else begin
									result_q <= make_ack(ST_NOCHG, cnt_q);
								end
							end
							OP_READ, OP_REMOVE_EQ, OP_REMOVE_LT: begin
								if (cnt_q != '0) begin
									state_q <= S_SCAN;
									jend_q  <= cnt_q - CW'(1);
								end else begin
									strobe_q <= 1'b1;
									result_q <= make_ack(ST_NOCHG, cnt_q);
								end
							end
							OP_SWAP, OP_ROT_L: begin
								if (cnt_q >= CW'(2)) begin
									state_q <= S_SCAN;
									jend_q  <= (q_cmd.op == OP_SWAP) ? CW'(1) : '0;
								end else begin
									strobe_q <= 1'b1;
									result_q <= make_ack(ST_NOCHG, cnt_q);
								end
							end
							OP_ROT_R: begin
								if (cnt_q >= CW'(2)) begin
									state_q <= S_SCAN;
									j_q     <= cnt_q - CW'(1);
									jend_q  <= cnt_q - CW'(1);
								end else begin
									strobe_q <= 1'b1;
									result_q <= make_ack(ST_NOCHG, cnt_q);
								end
							end
							OP_MOVE2: begin
								if (cnt_q >= CW'(3)) begin
									state_q <= S_SCAN;
									jend_q  <= cnt_q - CW'(1);
								end else begin
									strobe_q <= 1'b1;
									result_q <= make_ack(ST_NOCHG, cnt_q);
								end
							end
							default: begin
								strobe_q <= 1'b1;
								result_q <= make_ack(ST_NOCHG, cnt_q);
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						j_q <= j_q + CW'(1);
						if (j_q == jend_q) issued_q <= 1'b1;
					end
					if (proc) begin
						if (op_q == OP_READ) begin
							strobe_q <= 1'b1;
							result_q <= make_elem(rdata_s1, last_rd, cnt_q);
						end
						if (is_filter && keep) k_q <= k_q + CW'(1);
						if (op_q == OP_REMOVE_EQ && !keep) found_q <= 1'b1;
						// hold the entry that moves to its new place at the end
						if ((op_q == OP_MOVE2 && j_s1 == CW'(1))
								|| (op_q == OP_SWAP && j_s1 == '0)
								|| op_q == OP_ROT_L || op_q == OP_ROT_R) begin
							sv_q <= rdata_s1;
						end
						if (last_rd) state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					case (op_q) inside
						OP_READ: ;
						OP_REMOVE_EQ, OP_REMOVE_LT: begin
							strobe_q <= 1'b1;
							if (k_q != cnt_q) begin
								cnt_q    <= k_q;
								result_q <= make_ack(ST_DONE, k_q);
							end else begin
								result_q <= make_ack(ST_NOCHG, cnt_q);
							end
						end
						OP_MOVE2, OP_SWAP: begin
							strobe_q <= 1'b1;
							result_q <= make_ack(ST_DONE, cnt_q);
						end
						OP_ROT_R: begin
							front_q  <= front_dec;
							strobe_q <= 1'b1;
							result_q <= make_ack(ST_DONE, cnt_q);
						end
						OP_ROT_L: begin
							front_q  <= front_inc;
							strobe_q <= 1'b1;
							result_q <= make_ack(ST_DONE, cnt_q);
						end
						default: begin
							strobe_q <= 1'b1;
							result_q <= make_ack(ST_NOCHG, cnt_q);
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("entry count above depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= AW'(DEPTH - 1)) else $error("front position out of range");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && is_filter && keep) |-> (k_q <= j_s1))
		else $error("compaction write ahead of read");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_SCAN)) else $error("read data outside scan");

endmodule

`default_nettype wire

// ===== rtl/core/bounded_list_edit_engine.sv =====
// Top level of the bounded list edit engine.
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit entries kept as a ring in one
// memory. An action is taken when start is high and busy is low; the front
// queues up to two actions, so busy rises only when both slots are taken.
// Every action returns one acknowledgment with the entry count and status,
// except a read-out of a non-empty list, which streams its n entries one per
// cycle with the final one marked. Results appear on result for one cycle
// with strobe high and cannot be stalled. Append, drop-last and refused or
// unknown actions are answered from the back end's idle state. Actions that
// visit entries (remove, remove-less-than, move-second, read-out), swap and
// rotations pass a scan and a closing state: the list is walked through the
// single registered read port of the entry memory, one entry per cycle.

module bounded_list_edit_engine import ble_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    strobe,
	output result_t result
);

	logic q_valid;
	cmd_t q_cmd;
	logic pop;

	ble_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.pop     (pop)
	);

	ble_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.pop     (pop),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

`default_nettype wire

// ===== tb/sv/bounded_list_edit_engine_tb.sv =====
// Self-checking testbench for the bounded list edit engine.
`timescale 1ns / 1ps

module bounded_list_edit_engine_tb;
	import ble_pkg::*;

	localparam int DEPTH = 32;
	localparam int PHASE_ITEMS = 62;
	localparam int SETTLE_CYCLES = DEPTH + 8;
	localparam int unsigned ACT_UNDEF_LO = 9;
	localparam int unsigned ACT_UNDEF_HI = 15;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	// Holds the expected list contents and the results still owed by the block.
	class list_scoreboard;
		logic signed [31:0] entries[$];
		result_t            owed_q[$];
		int unsigned        mismatches;
		int unsigned        checked;
		int unsigned        taken;
		int unsigned        refusals;
		int unsigned        peak;

		function void note_item(item_t it);
			int                 n;
			int                 hit;
			logic signed [31:0] v;
			logic signed [31:0] kept[$];
			result_t            r;
			logic [1:0]         st;
			n   = entries.size();
			hit = -1;
			st  = ST_NOCHG;
			taken++;
			case (it.action)
				ACT_APPEND: begin
					if (n >= DEPTH) begin
						st = ST_FULL;
						refusals++;
					end else begin
						entries.push_back(it.value);
						st = ST_DONE;
					end
				end
				ACT_REMOVE_EQ: begin
					for (int i = 0; i < n; i++)
						if (hit < 0 && entries[i] == it.value)
							hit = i;
					if (hit >= 0) begin
						entries.delete(hit);
						st = ST_DONE;
					end
				end
				ACT_READ: begin
					if (n > 0) begin
						for (int i = 0; i < n; i++) begin
							r.kind        = KIND_ELEM;
							r.element     = entries[i];
							r.last        = (i == n - 1);
							r.entry_count = 6'(n);
							r.status      = ST_DONE;
							owed_q.push_back(r);
						end
						return;
					end
				end
				ACT_SWAP: begin
					if (n >= 2) begin
						v          = entries[0];
						entries[0] = entries[1];
						entries[1] = v;
						st         = ST_DONE;
					end
				end
				ACT_DROP: begin
					if (n >= 1) begin
						void'(entries.pop_back());
						st = ST_DONE;
					end
				end
				ACT_ROT_R: begin
					if (n >= 2) begin
						entries.push_front(entries.pop_back());
						st = ST_DONE;
					end
				end
				ACT_ROT_L: begin
					if (n >= 2) begin
						entries.push_back(entries.pop_front());
						st = ST_DONE;
					end
				end
				ACT_MOVE2: begin
					if (n >= 3) begin
						v = entries[1];
						entries.delete(1);
						entries.push_back(v);
						st = ST_DONE;
					end
				end
				ACT_REMOVE_LT: begin
					foreach (entries[i])
						if ($signed(entries[i]) >= $signed(it.value))
							kept.push_back(entries[i]);
					if (kept.size() != n) begin
						entries = kept;
						st      = ST_DONE;
					end
				end
				default: begin
					st = ST_NOCHG;
				end
			endcase
			if (entries.size() > peak)
				peak = entries.size();
			r.kind        = KIND_ACK;
			r.element     = '0;
			r.last        = 1'b1;
			r.entry_count = 6'(entries.size());
			r.status      = st;
			owed_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: unexpected result kind=%0d elem=%0d last=%0d ",
						"count=%0d status=%0d"},
						$time, got.kind, got.element, got.last, got.entry_count,
						got.status);
				return;
			end
			want = owed_q.pop_front();
			if (got.kind !== want.kind || got.element !== want.element ||
				got.last !== want.last || got.entry_count !== want.entry_count ||
				got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: result differs: exp kind=%0d elem=%0d last=%0d count=%0d ",
						"status=%0d, got kind=%0d elem=%0d last=%0d count=%0d status=%0d"},
						$time, want.kind, want.element, want.last, want.entry_count,
						want.status, got.kind, got.element, got.last, got.entry_count,
						got.status);
			end
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction

		function int count();
			return entries.size();
		endfunction

		function logic signed [31:0] any_entry();
			if (entries.size() == 0)
				return $urandom;
			return entries[$urandom_range(0, entries.size() - 1)];
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;

	list_scoreboard sb = new();

	bounded_list_edit_engine #(.DEPTH(DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("bounded_list_edit_engine: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (strobe)
			sb.check_result(result);
	end

	// Hold the transaction on the inputs until the block takes it.
	task automatic send(logic [3:0] act, logic signed [31:0] val);
		item_t it;
		it.action = act;
		it.value  = val;
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(it);
	endtask

	task automatic maybe_idle(int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, $urandom_range(0, 1) ? 3 : 40))
				@(posedge clk);
		end
	endtask

	// Drop start and hold off until every owed result has arrived.
	task automatic drain();
		start <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
			5, 6:    return sb.any_entry();
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < 32)      return ACT_APPEND;
		else if (r < 42) return ACT_REMOVE_EQ;
		else if (r < 50) return ACT_READ;
		else if (r < 56) return ACT_SWAP;
		else if (r < 63) return ACT_DROP;
		else if (r < 70) return ACT_ROT_R;
		else if (r < 77) return ACT_ROT_L;
		else if (r < 85) return ACT_MOVE2;
		else if (r < 93) return ACT_REMOVE_LT;
		else if (r < 97) return 4'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
		return 4'($urandom_range(0, ACT_UNDEF_HI));
	endfunction

	// Append until full, push two refused appends, then read the whole list.
	task automatic fill_list(int pct);
		while (sb.count() < DEPTH) begin
			send(ACT_APPEND, pick_value());
			maybe_idle(pct);
		end
		repeat (2) begin
			send(ACT_APPEND, pick_value());
			maybe_idle(pct);
		end
		send(ACT_READ, pick_value());
		maybe_idle(pct);
	endtask

	initial begin
		int idle_pct[4];
		int phase_end;
		idle_pct = '{0, 52, 0, 37};
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-list corner cases and undefined codes.
		send(ACT_READ, 32'sd0);
		send(ACT_DROP, 32'sd0);
		send(ACT_SWAP, 32'sd0);
		send(ACT_ROT_R, 32'sd0);
		send(ACT_ROT_L, 32'sd0);
		send(ACT_MOVE2, 32'sd0);
		send(ACT_REMOVE_LT, VAL_MAX);
		send(ACT_REMOVE_EQ, 32'sd5);
		send(4'(ACT_UNDEF_LO), VAL_MIN);
		send(4'(ACT_UNDEF_HI), -32'sd1);
		// Extremes and a duplicate, then every edit on a populated list.
		send(ACT_APPEND, VAL_MIN);
		send(ACT_APPEND, VAL_MAX);
		send(ACT_APPEND, 32'sd0);
		send(ACT_APPEND, -32'sd1);
		send(ACT_APPEND, VAL_MIN);
		send(ACT_READ, 32'sd0);
		send(ACT_REMOVE_EQ, VAL_MIN);
		send(ACT_REMOVE_EQ, 32'sd7);
		send(ACT_SWAP, 32'sd0);
		send(ACT_ROT_R, 32'sd0);
		send(ACT_ROT_L, 32'sd0);
		send(ACT_MOVE2, 32'sd0);
		send(ACT_REMOVE_LT, VAL_MIN);
		send(ACT_REMOVE_LT, 32'sd0);
		send(ACT_DROP, 32'sd0);
		send(ACT_READ, 32'sd0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			phase_end = sb.taken + PHASE_ITEMS;
			if (phase == 1 || phase == 3)
				fill_list(idle_pct[phase]);
			while (sb.taken < phase_end) begin
				send(pick_action(), pick_value());
				maybe_idle(idle_pct[phase]);
			end
			drain();
		end

		repeat (SETTLE_CYCLES)
			@(posedge clk);
		$display({"run: %0d transactions taken, %0d results checked, ",
			"all nine actions and undefined codes"},
			sb.taken, sb.checked);
		$display("run: list held up to %0d entries, %0d appends refused while full",
			sb.peak, sb.refusals);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("bounded_list_edit_engine: match");
		end else begin
			$display("%0d mismatches, %0d results never seen", sb.mismatches, sb.outstanding());
			$display("bounded_list_edit_engine: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ble_pkg.sv
rtl/core/ble_front.sv
rtl/core/ble_back.sv
rtl/core/bounded_list_edit_engine.sv
tb/sv/bounded_list_edit_engine_tb.sv
